>>> design/bpr_pkg.sv
package bpr_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 5;
    localparam int MAX_BYTES   = 16;
    localparam int BYTE_IDX_W  = $clog2(MAX_BYTES);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATCH_LENGTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PATCH_LOW      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PATCH_HIGH     = 3'd5;

    typedef enum logic {
        CMD_PASS = 1'b0,
        CMD_REPL = 1'b1
    } t_cmd_kind;

    // One queued command: a byte that passes through, or a whole replacement run.
    typedef struct packed {
        t_cmd_kind           kind;
        logic [BYTE_W-1:0]   data;
        logic                last;
    } t_cmd;

    // Effective settings seen by the front and back ends.
    typedef struct packed {
        logic [LEN_W-1:0]              len;
        logic [LEN_W-1:0]              patch_len;
        logic [MAX_BYTES*BYTE_W-1:0]   pattern;
        logic [MAX_BYTES*BYTE_W-1:0]   patch;
    } t_match_cfg;

endpackage

>>> design/bpr_front.sv
module bpr_front #(
    parameter int WIN_DEPTH = 17
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [bpr_pkg::BYTE_W-1:0] i_data,
    input  logic                       i_last,
    input  bpr_pkg::t_match_cfg        i_cfg,
    output logic                       o_cmd_valid,
    output bpr_pkg::t_cmd              o_cmd,
    input  logic                       i_cmd_ready
);
    import bpr_pkg::*;

    localparam int CAP    = WIN_DEPTH - 1;
    localparam int FILL_W = $clog2(WIN_DEPTH + 1);
    localparam int CMP_W  = LEN_W + 1;

    logic [BYTE_W-1:0] r_win [WIN_DEPTH];
    logic [BYTE_W-1:0] n_win [WIN_DEPTH];
    logic [BYTE_W-1:0] w_app [WIN_DEPTH];
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              r_busy, n_busy;
    logic              r_flush, n_flush;
    logic [CMP_W-1:0]  w_len, w_fill1;
    logic              w_match, w_accept, w_shift;

    always_comb begin
        w_len   = CMP_W'(i_cfg.len);
        w_fill1 = CMP_W'(r_fill) + CMP_W'(1);

        // Window as it stands with the incoming byte appended.
        for (int i = 0; i < WIN_DEPTH; i++) begin
            w_app[i] = (FILL_W'(i) == r_fill) ? i_data : r_win[i];
        end

        w_match = 1'b1;
        for (int i = 0; i < CAP; i++) begin
            if ((CMP_W'(i) < w_len) &&
                (w_app[i] != i_cfg.pattern[BYTE_W*i +: BYTE_W])) begin
                w_match = 1'b0;
            end
        end

        o_ready  = !r_busy && i_cmd_ready;
        w_accept = i_valid && o_ready;

        o_cmd_valid = 1'b0;
        o_cmd.kind  = CMD_PASS;
        o_cmd.data  = r_win[0];
        o_cmd.last  = 1'b0;
        w_shift     = 1'b0;
        n_fill      = r_fill;
        n_busy      = r_busy;
        n_flush     = r_flush;
        n_win       = r_win;

        if (r_busy) begin
            // Drain: second pop after a length change, or the flush after a final byte.
            if (i_cmd_ready) begin
                o_cmd_valid = 1'b1;
                o_cmd.last  = r_flush && (r_fill == FILL_W'(1));
                w_shift     = 1'b1;
                n_fill      = r_fill - FILL_W'(1);
                n_busy      = r_flush && (r_fill != FILL_W'(1));
            end
        end else if (w_accept) begin
            n_win   = w_app;
            n_flush = i_last;
            if ((w_fill1 == w_len) && w_match) begin
                o_cmd_valid = 1'b1;
                o_cmd.kind  = CMD_REPL;
                o_cmd.last  = i_last;
                n_fill      = '0;
            end else if ((w_fill1 >= w_len) || i_last) begin
                o_cmd_valid = 1'b1;
                o_cmd.data  = w_app[0];
                o_cmd.last  = i_last && (w_fill1 == CMP_W'(1));
                w_shift     = 1'b1;
                n_fill      = FILL_W'(w_fill1 - CMP_W'(1));
                n_busy      = (w_fill1 > w_len) || (i_last && (w_fill1 > CMP_W'(1)));
            end else begin
                n_fill = FILL_W'(w_fill1);
            end
        end

        if (w_shift) begin
            for (int i = 0; i < WIN_DEPTH - 1; i++) begin
                n_win[i] = n_win[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_busy  <= 1'b0;
            r_flush <= 1'b0;
        end else begin
            r_fill  <= n_fill;
            r_busy  <= n_busy;
            r_flush <= n_flush;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

`ifndef SYNTHESIS
    a_busy_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_fill != '0))
        else $error("front drain running on an empty window");

    a_flush_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(r_busy) && $past(r_flush)) |-> (r_fill == '0))
        else $error("window not empty after flush");
`endif

endmodule

>>> design/bpr_queue.sv
module bpr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  bpr_pkg::t_cmd i_push_data,
    output logic          o_pop_valid,
    output bpr_pkg::t_cmd o_pop_data,
    input  logic          i_pop
);
    import bpr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push, w_pop;

    always_comb begin
        o_push_ready = (r_count != CNT_W'(QUEUE_DEPTH));
        o_pop_valid  = (r_count != '0);
        o_pop_data   = r_mem[r_rd_ptr];
        w_push       = i_push_valid && o_push_ready;
        w_pop        = i_pop && o_pop_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("command queue count out of range");
`endif

endmodule

>>> design/bpr_back.sv
module bpr_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cmd_valid,
    input  bpr_pkg::t_cmd              i_cmd,
    output logic                       o_cmd_pop,
    input  bpr_pkg::t_match_cfg        i_cfg,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [bpr_pkg::BYTE_W-1:0] o_data,
    output logic                       o_user,
    output logic                       o_last
);
    import bpr_pkg::*;

    logic [BYTE_IDX_W-1:0] r_cnt, n_cnt;
    logic                  r_valid, n_valid;
    logic [BYTE_W-1:0]     r_data, n_data;
    logic                  r_user, n_user;
    logic                  r_last, n_last;
    logic                  w_load, w_run_end;
    logic [BYTE_W-1:0]     w_patch_byte;

    always_comb begin
        w_load       = !r_valid || i_ready;
        w_run_end    = (LEN_W'(r_cnt) + LEN_W'(1)) == i_cfg.len;
        w_patch_byte = (LEN_W'(r_cnt) < i_cfg.patch_len) ?
                       i_cfg.patch[BYTE_W*r_cnt +: BYTE_W] : '0;

        o_cmd_pop = 1'b0;
        n_cnt     = r_cnt;
        n_valid   = r_valid;
        n_data    = r_data;
        n_user    = r_user;
        n_last    = r_last;

        if (w_load) begin
            n_valid = i_cmd_valid;
            if (i_cmd_valid) begin
                case (i_cmd.kind)
                    CMD_PASS: begin
                        n_data    = i_cmd.data;
                        n_user    = 1'b0;
                        n_last    = i_cmd.last;
                        o_cmd_pop = 1'b1;
                    end
                    CMD_REPL: begin
                        // Patch bytes, then zeros, up to the pattern length.
                        n_data    = w_patch_byte;
                        n_user    = 1'b1;
                        n_last    = i_cmd.last && w_run_end;
                        o_cmd_pop = w_run_end;
                        n_cnt     = w_run_end ? '0 : r_cnt + BYTE_IDX_W'(1);
                    end
                    default: begin
                        n_valid = 1'b0;
                    end
                endcase
            end
        end

        o_valid = r_valid;
        o_data  = r_data;
        o_user  = r_user;
        o_last  = r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_user <= n_user;
        r_last <= n_last;
    end

`ifndef SYNTHESIS
    a_run_holds_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> (i_cmd_valid && (i_cmd.kind == CMD_REPL)))
        else $error("replacement run lost its queue entry");
`endif

endmodule

>>> design/byte_pattern_replace_top.sv
// Byte-stream search and replace. Bytes enter on the slave stream, one per transfer, into a
// window that holds the last pattern_length bytes. When the window equals the configured
// pattern, pattern_length bytes leave on the master stream in its place: the patch bytes,
// then zeros, all flagged in tuser; the window is then cleared, so matches are taken
// leftmost first and never overlap. Otherwise the oldest window byte leaves unchanged. A
// byte with tlast set flushes the window after its match test, and the last output byte
// of that step carries tlast. In steady state the block takes one byte per cycle and gives
// one per cycle; the output side moves one byte per cycle, so a match holds it for
// pattern_length bytes and a final byte for each byte left in the window, during which the
// four-entry command queue between the front end and the output stage fills and the slave
// side is held off. A pattern_length lowered below the window fill adds a drained byte
// after each input byte, holding off the slave side, until the window has shrunk. Output
// is registered behind the queue. Write the configuration only while the block is idle.
module byte_pattern_replace_top #(
    parameter int MAX_PATTERN = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [bpr_pkg::BYTE_W-1:0]     i_s_axis_tdata,   // data_byte
    input  logic                           i_s_axis_tlast,   // final_byte

    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [bpr_pkg::BYTE_W-1:0]     o_m_axis_tdata,   // out_byte
    output logic                           o_m_axis_tuser,   // replaced
    output logic                           o_m_axis_tlast,   // out_final

    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bpr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bpr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bpr_pkg::*;

    // Longest pattern in use; the window needs one spare entry for the byte that
    // arrives after the length has been lowered.
    localparam int CAP       = (MAX_PATTERN < MAX_BYTES) ? MAX_PATTERN : MAX_BYTES;
    localparam int WIN_DEPTH = CAP + 1;

    logic [LEN_W-1:0]      r_pattern_length;
    logic [LEN_W-1:0]      r_patch_length;
    logic [CFG_DATA_W-1:0] r_pattern_low, r_pattern_high;
    logic [CFG_DATA_W-1:0] r_patch_low, r_patch_high;
    t_match_cfg            w_cfg;
    logic [LEN_W-1:0]      w_len;

    logic                  w_cmd_valid, w_cmd_ready;
    t_cmd                  w_cmd;
    logic                  w_q_valid, w_q_pop;
    t_cmd                  w_q_cmd;

    // The register file never stalls a write.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_length <= LEN_W'(1);
            r_patch_length   <= '0;
            r_pattern_low    <= '0;
            r_pattern_high   <= '0;
            r_patch_low      <= '0;
            r_patch_high     <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_PATTERN_LENGTH: r_pattern_length <= i_cfg_data[LEN_W-1:0];
                REG_PATCH_LENGTH:   r_patch_length   <= i_cfg_data[LEN_W-1:0];
                REG_PATTERN_LOW:    r_pattern_low    <= i_cfg_data;
                REG_PATTERN_HIGH:   r_pattern_high   <= i_cfg_data;
                REG_PATCH_LOW:      r_patch_low      <= i_cfg_data;
                REG_PATCH_HIGH:     r_patch_high     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // A pattern length of zero counts as one, and anything beyond the window is clipped.
    // The patch never runs longer than the pattern.
    always_comb begin
        if (r_pattern_length == '0) begin
            w_len = LEN_W'(1);
        end else if (r_pattern_length > LEN_W'(CAP)) begin
            w_len = LEN_W'(CAP);
        end else begin
            w_len = r_pattern_length;
        end
        w_cfg.len       = w_len;
        w_cfg.patch_len = (r_patch_length > w_len) ? w_len : r_patch_length;
        w_cfg.pattern   = {r_pattern_high, r_pattern_low};
        w_cfg.patch     = {r_patch_high, r_patch_low};
    end

    // Front end: window, match test, and the drain after a final byte.
    bpr_front #(
        .WIN_DEPTH (WIN_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_data      (i_s_axis_tdata),
        .i_last      (i_s_axis_tlast),
        .i_cfg       (w_cfg),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_ready (w_cmd_ready)
    );

    // Command queue lets the front keep taking bytes while a replacement run streams out.
    bpr_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_cmd_valid),
        .o_push_ready (w_cmd_ready),
        .i_push_data  (w_cmd),
        .o_pop_valid  (w_q_valid),
        .o_pop_data   (w_q_cmd),
        .i_pop        (w_q_pop)
    );

    // Back end: expands commands into output bytes behind a registered output stage.
    bpr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_cmd_pop   (w_q_pop),
        .i_cfg       (w_cfg),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_data      (o_m_axis_tdata),
        .o_user      (o_m_axis_tuser),
        .o_last      (o_m_axis_tlast)
    );

endmodule
